// ===== rtl/multi_voice_sample_mixer_macros.svh =====
// Assertion helpers for the mixer checker
`ifndef MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH
`define MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define MVSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define MVSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mvsm_pkg.sv =====
`timescale 1ns / 1ps
package mvsm_pkg;
    localparam int VOICES_DEF = 32;
    localparam int SAMPLE_WORDS_DEF = 65536;
    localparam int OUTPUT_RATE_RESET = 44100;
    localparam int PITCH_MIN = 410;
    localparam int PITCH_MAX = 40960;
    localparam int HALF_Q15 = 16384;
    localparam int MAX_LENGTH = 65536;

    localparam logic [2:0] REQ_LOAD = 3'd0;
    localparam logic [2:0] REQ_PLAY = 3'd1;
    localparam logic [2:0] REQ_STOP = 3'd2;
    localparam logic [2:0] REQ_STOP_BASE = 3'd3;
    localparam logic [2:0] REQ_TICK = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [15:0]        mem_addr;
        logic signed [15:0] mem_data;
        logic [16:0]        sample_length;
        logic [17:0]        native_rate;
        logic [15:0]        voice_gain;
        logic [15:0]        voice_pitch;
        logic signed [15:0] voice_pan;
        logic [4:0]         voice_select;
    } req_t;

    typedef struct packed {
        logic [4:0]         voice_index;
        logic               voice_found;
        logic [5:0]         active_count;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } rsp_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v < -48'sd32768)
        begin
            r = -16'sd32768;
        end
        else if (v > 48'sd32767)
        begin
            r = 16'sd32767;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction
endpackage

// ===== rtl/mvsm_if.sv =====
`timescale 1ns / 1ps
interface mvsm_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mvsm_front.sv =====
`timescale 1ns / 1ps
// Two-entry request queue between port and engine
module mvsm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mvsm_pkg::req_t  in_data,
    output logic            q_valid,
    input  logic            q_ready,
    output mvsm_pkg::req_t  q_data
);
    import mvsm_pkg::*;

    req_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store incoming item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/mvsm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module mvsm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [37:0] dividend,
    input  logic [17:0] divisor,
    output logic        done,
    output logic [37:0] quotient
);
    logic [37:0] quo_reg;
    logic [18:0] rem_reg;
    logic [17:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [18:0] shifted;
    logic [18:0] diff;

    assign shifted  = {rem_reg[17:0], quo_reg[37]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    // Hold operands and shift one bit each cycle while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[18])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[36:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[36:0], 1'b0};
            end
        end
    end

    // Count iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd37)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/mvsm_engine.sv =====
`timescale 1ns / 1ps
// Voice table, sample memory and mixing sequencer
module mvsm_engine #(
    parameter int VOICES = mvsm_pkg::VOICES_DEF,
    parameter int SAMPLE_WORDS = mvsm_pkg::SAMPLE_WORDS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [17:0]     cfg_data,
    input  logic            q_valid,
    output logic            q_ready,
    input  mvsm_pkg::req_t  q_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mvsm_pkg::rsp_t  out_data
);
    import mvsm_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int AW = $clog2(SAMPLE_WORDS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_DIVW = 4'd3;
    localparam logic [3:0] S_T0   = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_T2   = 4'd6;
    localparam logic [3:0] S_T3   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;

    logic [15:0] smem [SAMPLE_WORDS];
    logic        act_reg  [VOICES];
    logic        past_reg [VOICES];
    logic [15:0] base_reg [VOICES];
    logic [16:0] len_reg  [VOICES];
    logic [31:0] pos_reg  [VOICES];
    logic [31:0] step_reg [VOICES];
    logic [15:0] lvl_reg  [VOICES];
    logic signed [15:0] bal_reg [VOICES];

    logic [3:0]  state_reg;
    logic [17:0] orate_reg;
    req_t        req_reg;
    logic [VW:0] vi_reg;
    logic [VW-1:0] vsel;
    logic [CW-1:0] cnt_reg;
    logic signed [15:0] word_reg;
    logic signed [15:0] t_reg;
    logic signed [47:0] lsum_reg;
    logic signed [47:0] rsum_reg;
    logic signed [31:0] lp_reg;
    logic signed [31:0] rp_reg;
    logic signed [31:0] prod_reg;
    logic [33:0] rp_mul_reg;
    rsp_t        rsp_reg;
    logic        div_start;
    logic        div_done;
    logic [37:0] div_quo;
    logic [15:0] pitch_c;
    logic [AW-1:0] raddr;
    logic [32:0] nextpos;
    logic        last_voice;

    assign vsel       = vi_reg[VW-1:0];
    assign last_voice = (vi_reg == (VW+1)'(VOICES - 1));
    assign q_ready    = (state_reg == S_IDLE) && !out_valid;
    assign cfg_ready  = 1'b1;
    assign out_data   = rsp_reg;
    assign pitch_c    = (q_data.voice_pitch < 16'(PITCH_MIN)) ? 16'(PITCH_MIN) :
                        (q_data.voice_pitch > 16'(PITCH_MAX)) ? 16'(PITCH_MAX) :
                        q_data.voice_pitch;
    assign raddr      = AW'({16'd0, base_reg[vsel]} + {16'd0, pos_reg[vsel][31:16]});
    assign nextpos    = {1'b0, pos_reg[vsel]} + {1'b0, step_reg[vsel]};
    assign div_start  = (state_reg == S_DIV);

    mvsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({rp_mul_reg, 4'd0}),
        .divisor  ((orate_reg == 18'd0) ? 18'd1 : orate_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Write and read sample memory
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready && q_data.req_type == REQ_LOAD)
        begin
            smem[AW'(q_data.mem_addr)] <= q_data.mem_data;
        end
        word_reg <= smem[raddr];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            req_reg    <= q_data;
            rp_mul_reg <= 34'(q_data.native_rate) * 34'(pitch_c);
        end
        prod_reg <= word_reg * $signed({1'b0, lvl_reg[vsel]});
        t_reg    <= sat16(48'(prod_reg >>> 12));
        lp_reg   <= t_reg * (32'sd16384 - 32'(bal_reg[vsel]));
        rp_reg   <= t_reg * (32'sd16384 + 32'(bal_reg[vsel]));
    end

    // Sequence requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            orate_reg <= 18'(OUTPUT_RATE_RESET);
            vi_reg    <= '0;
            cnt_reg   <= '0;
            lsum_reg  <= '0;
            rsum_reg  <= '0;
            out_valid <= 1'b0;
            rsp_reg   <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                act_reg[i]  <= 1'b0;
                past_reg[i] <= 1'b0;
                base_reg[i] <= '0;
                len_reg[i]  <= '0;
                pos_reg[i]  <= '0;
                step_reg[i] <= '0;
                lvl_reg[i]  <= '0;
                bal_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                orate_reg <= cfg_data;
            end
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    vi_reg   <= '0;
                    lsum_reg <= '0;
                    rsum_reg <= '0;
                    if (q_valid && q_ready)
                    begin
                        rsp_reg <= '0;
                        case (q_data.req_type)
                            REQ_PLAY:
                            begin
                                state_reg <= S_SCAN;
                            end
                            REQ_TICK:
                            begin
                                state_reg <= S_T0;
                            end
                            REQ_STOP:
                            begin
                                if (32'(q_data.voice_select) < VOICES)
                                begin
                                    if (act_reg[VW'(q_data.voice_select)])
                                    begin
                                        cnt_reg <= cnt_reg - CW'(1);
                                    end
                                    act_reg[VW'(q_data.voice_select)]  <= 1'b0;
                                    past_reg[VW'(q_data.voice_select)] <= 1'b0;
                                end
                                state_reg <= S_FIN;
                            end
                            REQ_STOP_BASE:
                            begin
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // Walk voices one a cycle
                    if (req_reg.req_type == REQ_PLAY)
                    begin
                        if (!act_reg[vsel])
                        begin
                            state_reg <= S_DIV;
                        end
                        else if (last_voice)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            vi_reg <= vi_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (act_reg[vsel] && base_reg[vsel] == req_reg.mem_addr)
                        begin
                            act_reg[vsel]  <= 1'b0;
                            past_reg[vsel] <= 1'b0;
                            cnt_reg        <= cnt_reg - CW'(1);
                        end
                        if (last_voice)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            vi_reg <= vi_reg + 1'b1;
                        end
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        act_reg[vsel]  <= 1'b1;
                        past_reg[vsel] <= 1'b0;
                        base_reg[vsel] <= req_reg.mem_addr;
                        len_reg[vsel]  <= (req_reg.sample_length > 17'(MAX_LENGTH)) ?
                                          17'(MAX_LENGTH) : req_reg.sample_length;
                        pos_reg[vsel]  <= '0;
                        step_reg[vsel] <= (div_quo[37:32] != 6'd0) ? 32'hFFFF_FFFF :
                                          div_quo[31:0];
                        lvl_reg[vsel]  <= req_reg.voice_gain;
                        bal_reg[vsel]  <= req_reg.voice_pan >>> 1;
                        cnt_reg        <= cnt_reg + CW'(1);
                        rsp_reg.voice_index <= 5'(vsel);
                        rsp_reg.voice_found <= 1'b1;
                        state_reg      <= S_FIN;
                    end
                end
                S_T0:
                begin
                    // Skip idle voices, retire finished voices or start the word read
                    if (!act_reg[vsel])
                    begin
                        state_reg <= last_voice ? S_FIN : S_T0;
                        vi_reg    <= vi_reg + 1'b1;
                    end
                    else if (past_reg[vsel] || {1'b0, pos_reg[vsel][31:16]} >= len_reg[vsel])
                    begin
                        act_reg[vsel]  <= 1'b0;
                        past_reg[vsel] <= 1'b0;
                        cnt_reg        <= cnt_reg - CW'(1);
                        state_reg      <= last_voice ? S_FIN : S_T0;
                        vi_reg         <= vi_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_T1;
                    end
                end
                S_T1:
                begin
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    lsum_reg <= lsum_reg + 48'(sat16(48'(lp_reg >>> 15)));
                    rsum_reg <= rsum_reg + 48'(sat16(48'(rp_reg >>> 15)));
                    pos_reg[vsel] <= nextpos[32] ? 32'hFFFF_FFFF : nextpos[31:0];
                    if (nextpos[32])
                    begin
                        past_reg[vsel] <= 1'b1;
                    end
                    state_reg <= last_voice ? S_FIN : S_T0;
                    vi_reg    <= vi_reg + 1'b1;
                end
                S_FIN:
                begin
                    if (req_reg.req_type == REQ_TICK)
                    begin
                        rsp_reg.left_out  <= sat16(lsum_reg);
                        rsp_reg.right_out <= sat16(rsum_reg);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    rsp_reg.active_count <= 6'(cnt_reg);
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/multi_voice_sample_mixer.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Payload
// cfg      | in  | output_rate, 18 bits
// req      | in  | request item (req_t)
// rsp      | out | result item (rsp_t)
// Steps below run from request acceptance at the engine to result valid.
// Play: scan voices up to the first free one, then wait on the bit-serial
// step divider (38 quotient bits), then the finish and output states.
// Tick: idle or ending voices are passed in T0; playing voices go T0 to T3, ACC.
// Stop by base and a play with no free voice walk every voice; others go to finish.
// rst_n clears the voice table and control state; sample memory is not cleared.
// Two requests queue at the front; one result waits in the output register.
module multi_voice_sample_mixer #(
    parameter int VOICES = mvsm_pkg::VOICES_DEF,
    parameter int SAMPLE_WORDS = mvsm_pkg::SAMPLE_WORDS_DEF
) (
    input logic clk,
    input logic rst_n,
    mvsm_if.sink   cfg,
    mvsm_if.sink   req,
    mvsm_if.source rsp
);
    import mvsm_pkg::*;

    logic q_valid;
    logic q_ready;
    req_t q_data;
    rsp_t rsp_data;

    mvsm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .in_data  (req_t'(req.data)),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    mvsm_engine #(
        .VOICES       (VOICES),
        .SAMPLE_WORDS (SAMPLE_WORDS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_data  (18'(cfg.data)),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp_data)
    );

    assign rsp.data = rsp_data;
endmodule

// ===== rtl/mvsm_checker.sv =====
`timescale 1ns / 1ps
`include "multi_voice_sample_mixer_macros.svh"
// Port-level checks on the mixer
module mvsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [43:0] rsp_data
);
    // Result stays until taken
    `MVSM_ASSERT_NXT(a_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped")
    // Active count never exceeds table size
    `MVSM_ASSERT_IMP(a_count, clk, rst_n, rsp_valid, rsp_data[37:32] <= 6'd32, "count too large")
    // A found voice is never reported with zero active
    `MVSM_ASSERT_IMP(a_found, clk, rst_n, rsp_valid && rsp_data[38], rsp_data[37:32] != 6'd0, "found with none active")
    // Results are separated: no back-to-back results
    `MVSM_ASSERT_NXT(a_gap, clk, rst_n, rsp_valid && rsp_ready, !rsp_valid, "result repeated")
endmodule

bind multi_voice_sample_mixer mvsm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import mvsm_pkg::*;

    localparam int NV = 32;
    localparam int RANDOM_PER_PHASE = 305;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        req_t r;
        bit   chk;
        rsp_t e;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mvsm_if #(.W(18)) cfg_ch();
    mvsm_if #(.W($bits(req_t))) req_ch();
    mvsm_if #(.W($bits(rsp_t))) rsp_ch();

    multi_voice_sample_mixer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_ch),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // mirror of the mixer state
    logic signed [15:0] mem_m [0:65535];
    bit                 mem_written [0:65535];
    logic [17:0]        rate_m;
    bit                 act_m [0:NV-1];
    bit                 past_m [0:NV-1];
    logic [15:0]        base_m [0:NV-1];
    logic [16:0]        len_m [0:NV-1];
    logic [31:0]        pos_m [0:NV-1];
    logic [31:0]        step_m [0:NV-1];
    logic [15:0]        level_m [0:NV-1];
    longint             bal_m [0:NV-1];

    rsp_t   frames_due[$];
    int     errors = 0;
    int     results_seen = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    int     items_sent = 0;
    row_t   dir_rows[$];

    always #5 clk = ~clk;

    function automatic longint clip16(longint v);
        if (v < -32768)
        begin
            return -32768;
        end
        if (v > 32767)
        begin
            return 32767;
        end
        return v;
    endfunction

    function automatic void clear_voice(int i);
        act_m[i] = 0;
        past_m[i] = 0;
        base_m[i] = '0;
        len_m[i] = '0;
        pos_m[i] = '0;
        step_m[i] = '0;
        level_m[i] = '0;
        bal_m[i] = 0;
    endfunction

    // compute the response for one request and advance the mirror
    function automatic rsp_t mix_predict(req_t r);
        rsp_t o;
        int i;
        int n;
        longint unsigned st;
        longint unsigned pitch;
        longint unsigned orate;
        longint unsigned nxt;
        longint lsum;
        longint rsum;
        longint s;
        longint t;
        logic [31:0] whole;
        o = '0;
        lsum = 0;
        rsum = 0;
        case (r.req_type)
            REQ_LOAD:
            begin
                mem_m[r.mem_addr] = r.mem_data;
                mem_written[r.mem_addr] = 1;
            end
            REQ_PLAY:
            begin
                for (i = 0; i < NV; i++)
                begin
                    if (!act_m[i])
                    begin
                        break;
                    end
                end
                if (i < NV)
                begin
                    pitch = r.voice_pitch;
                    if (pitch < PITCH_MIN)
                    begin
                        pitch = PITCH_MIN;
                    end
                    if (pitch > PITCH_MAX)
                    begin
                        pitch = PITCH_MAX;
                    end
                    orate = (rate_m == 0) ? 1 : rate_m;
                    st = (longint'(r.native_rate) * pitch * 16) / orate;
                    if (st > 64'hFFFF_FFFF)
                    begin
                        st = 64'hFFFF_FFFF;
                    end
                    act_m[i] = 1;
                    past_m[i] = 0;
                    base_m[i] = r.mem_addr;
                    len_m[i] = (r.sample_length > MAX_LENGTH) ? 17'(MAX_LENGTH)
                                                               : r.sample_length;
                    pos_m[i] = '0;
                    step_m[i] = st[31:0];
                    level_m[i] = r.voice_gain;
                    bal_m[i] = longint'(r.voice_pan) >>> 1;
                    o.voice_index = i[4:0];
                    o.voice_found = 1'b1;
                end
            end
            REQ_STOP:
            begin
                if (r.voice_select < NV)
                begin
                    clear_voice(r.voice_select);
                end
            end
            REQ_STOP_BASE:
            begin
                for (i = 0; i < NV; i++)
                begin
                    if (act_m[i] && base_m[i] == r.mem_addr)
                    begin
                        clear_voice(i);
                    end
                end
            end
            REQ_TICK:
            begin
                for (i = 0; i < NV; i++)
                begin
                    if (!act_m[i])
                    begin
                        continue;
                    end
                    whole = pos_m[i] >> 16;
                    if (past_m[i] || whole >= len_m[i])
                    begin
                        clear_voice(i);
                        continue;
                    end
                    s = longint'(mem_m[16'(base_m[i] + whole)]);
                    t = clip16((s * longint'(level_m[i])) >>> 12);
                    lsum += clip16((t * (HALF_Q15 - bal_m[i])) >>> 15);
                    rsum += clip16((t * (HALF_Q15 + bal_m[i])) >>> 15);
                    nxt = longint'(pos_m[i]) + longint'(step_m[i]);
                    if (nxt > 64'hFFFF_FFFF)
                    begin
                        nxt = 64'hFFFF_FFFF;
                        past_m[i] = 1;
                    end
                    pos_m[i] = nxt[31:0];
                end
                o.left_out = 16'(clip16(lsum));
                o.right_out = 16'(clip16(rsum));
            end
            default:
            begin
            end
        endcase
        n = 0;
        for (i = 0; i < NV; i++)
        begin
            n += act_m[i];
        end
        o.active_count = n[5:0];
        return o;
    endfunction

    function automatic req_t mk(logic [2:0] ty, logic [15:0] addr, logic [15:0] data,
                                logic [16:0] len, logic [17:0] rate, logic [15:0] gain,
                                logic [15:0] pitch, logic [15:0] pan, logic [4:0] sel);
        req_t r;
        r.req_type = ty;
        r.mem_addr = addr;
        r.mem_data = data;
        r.sample_length = len;
        r.native_rate = rate;
        r.voice_gain = gain;
        r.voice_pitch = pitch;
        r.voice_pan = pan;
        r.voice_select = sel;
        return r;
    endfunction

    function automatic req_t rand_fields();
        req_t r;
        r = '0;
        r.mem_addr = 16'($urandom);
        r.mem_data = 16'($urandom);
        r.sample_length = 17'($urandom);
        r.native_rate = 18'($urandom_range(0, 192000));
        r.voice_gain = 16'($urandom);
        r.voice_pitch = 16'($urandom);
        r.voice_pan = 16'($urandom);
        r.voice_select = 5'($urandom);
        return r;
    endfunction

    // drive one item; valid stays high across back-to-back items
    task automatic send_item(req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic emit(req_t r);
        frames_due.push_back(mix_predict(r));
        send_item(r);
    endtask

    // load any unwritten word a playing voice is about to read, then tick
    task automatic emit_tick();
        int i;
        logic [15:0] a;
        req_t ld;
        for (i = 0; i < NV; i++)
        begin
            if (act_m[i] && !past_m[i] && (pos_m[i] >> 16) < len_m[i])
            begin
                a = 16'(base_m[i] + (pos_m[i] >> 16));
                if (!mem_written[a])
                begin
                    ld = rand_fields();
                    ld.req_type = REQ_LOAD;
                    ld.mem_addr = a;
                    emit(ld);
                end
            end
        end
        emit(mk(REQ_TICK, 16'($urandom), 16'($urandom), 17'($urandom), 18'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 5'($urandom)));
    endtask

    // wait for every result, then write the rate register
    task automatic write_rate(logic [17:0] v);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        rate_m = v;
    endtask

    task automatic random_item();
        req_t r;
        int pick;
        r = rand_fields();
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            emit_tick();
            return;
        end
        if (pick < 70)
        begin
            r.req_type = REQ_PLAY;
            if ($urandom_range(0, 1))
            begin
                r.mem_addr = 16'($urandom_range(0, 7) * 64);
            end
            case ($urandom_range(0, 9))
                0: r.sample_length = 17'd0;
                1, 2: r.sample_length = 17'($urandom);
                default: r.sample_length = 17'($urandom_range(1, 40));
            endcase
            if ($urandom_range(0, 2) == 0)
            begin
                r.native_rate = 18'd44100;
            end
        end
        else if (pick < 85)
        begin
            r.req_type = REQ_LOAD;
        end
        else if (pick < 92)
        begin
            r.req_type = REQ_STOP;
        end
        else if (pick < 97)
        begin
            r.req_type = REQ_STOP_BASE;
            if ($urandom_range(0, 1))
            begin
                r.mem_addr = 16'($urandom_range(0, 7) * 64);
            end
        end
        else
        begin
            r.req_type = 3'($urandom_range(5, 7));
        end
        emit(r);
    endtask

    task automatic report_field(string name, longint e, longint a);
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
        errors++;
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            results_seen++;
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (got.voice_index !== want.voice_index)
                    report_field("voice_index", want.voice_index, got.voice_index);
                if (got.voice_found !== want.voice_found)
                    report_field("voice_found", want.voice_found, got.voice_found);
                if (got.active_count !== want.active_count)
                    report_field("active_count", want.active_count, got.active_count);
                if (got.left_out !== want.left_out)
                    report_field("left_out", want.left_out, got.left_out);
                if (got.right_out !== want.right_out)
                    report_field("right_out", want.right_out, got.right_out);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("multi_voice_sample_mixer test failed");
                $finish;
            end
        end
    end

    // receiver: changing stall pattern plus one long hold-off
    initial
    begin
        int cyc;
        int mode;
        bit held;
        cyc = 0;
        held = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && results_seen >= 300)
            begin
                held = 1;
                rsp_ch.ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else
            begin
                mode = (cyc / 150) % 3;
                if (mode == 0)
                    rsp_ch.ready <= 1'b1;
                else if (mode == 1)
                    rsp_ch.ready <= 1'($urandom_range(0, 1));
                else
                    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // stimulus
    initial
    begin
        int i;
        int ph;
        int phase_end;
        row_t row;
        logic [17:0] rates [0:4];
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rate_m = 18'(OUTPUT_RATE_RESET);
        for (i = 0; i < NV; i++)
        begin
            clear_voice(i);
        end
        for (i = 0; i < 65536; i++)
        begin
            mem_m[i] = '0;
            mem_written[i] = 0;
        end

        // directed table
        row.chk = 1; row.e = '0;
        row.r = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.r = mk(REQ_STOP, 0, 0, 0, 0, 0, 0, 0, 31); dir_rows.push_back(row);
        row.r = mk(3'd7, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 18'd192000, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 5'h1F);
        dir_rows.push_back(row);
        row.r = mk(REQ_LOAD, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.r = mk(REQ_LOAD, 1, 16'h8000, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.r = mk(REQ_LOAD, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        row.r = mk(REQ_PLAY, 0, 0, 2, 44100, 4096, 4096, 0, 0);
        row.e = '0; row.e.voice_found = 1; row.e.active_count = 1; dir_rows.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        row.e.voice_found = 0; row.e.left_out = 16383; row.e.right_out = 16383;
        dir_rows.push_back(row);
        row.e.left_out = -16384; row.e.right_out = -16384; dir_rows.push_back(row);
        row.e = '0; dir_rows.push_back(row);
        // clamps: huge length, low pitch, full left pan; then zero length and rate
        row.chk = 0;
        row.r = mk(REQ_PLAY, 16'hFFFF, 0, 17'h1FFFF, 18'd192000, 16'hFFFF, 0, 16'h8000, 0);
        dir_rows.push_back(row);
        row.r = mk(REQ_PLAY, 1, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'h7FFF, 0);
        dir_rows.push_back(row);
        row.r = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);
        dir_rows.push_back(row);
        row.r = mk(REQ_PLAY, 0, 0, 3, 1, 16'h1000, 16'h1000, 16'h0001, 0);
        dir_rows.push_back(row);
        row.chk = 1; row.e = '0;
        row.r = mk(REQ_STOP_BASE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
        row.e.active_count = 1; dir_rows.push_back(row);
        row.e.active_count = 0;
        row.r = mk(REQ_STOP, 0, 0, 0, 0, 0, 0, 0, 1); dir_rows.push_back(row);
        row.r = mk(REQ_STOP, 0, 0, 0, 0, 0, 0, 0, 0); dir_rows.push_back(row);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            if (row.chk)
            begin
                void'(mix_predict(row.r));
                frames_due.push_back(row.e);
                send_item(row.r);
            end
            else
            begin
                emit(row.r);
            end
        end

        // random phases over several rate settings
        rates[0] = 18'd1;
        rates[1] = 18'd0;
        rates[2] = 18'd192000;
        rates[3] = 18'h3FFFF;
        rates[4] = 18'($urandom_range(1, 192000));
        for (ph = 0; ph < 5; ph++)
        begin
            write_rate(rates[ph]);
            phase_end = items_sent + RANDOM_PER_PHASE;
            while (items_sent < phase_end)
            begin
                random_item();
            end
        end

        // drain and finish
        req_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && frames_due.size() == 0)
        begin
            $display("multi_voice_sample_mixer test passed");
        end
        else
        begin
            $display("multi_voice_sample_mixer test failed");
        end
        $finish;
    end
endmodule
